// ===== rtl/ntcma_pkg.sv =====
`default_nettype none

package ntcma_pkg;

  // converter full scale and temperature limits
  localparam logic [11:0]        CODE_FULL    = 12'd4095;
  localparam logic [16:0]        KELVIN_CENTI = 17'd27315;
  localparam logic signed [16:0] TEMP_LOW     = -17'sd27315;
  localparam logic signed [16:0] TEMP_HIGH    = 17'sd30000;
  // highest quotient before clamping, TEMP_HIGH + KELVIN_CENTI
  localparam logic [15:0]        QUOT_MAX     = 16'd57315;
  // ln(2) in Q30
  localparam logic [29:0]        LN2_Q30      = 30'd744261118;
  localparam int                 FRAC_BITS    = 24;
  localparam int                 DIV_STEPS    = 16;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_FIXED_RES = 2'd0,
    CFG_BETA      = 2'd1,
    CFG_REF_RES   = 2'd2,
    CFG_REF_TEMP  = 2'd3
  } cfg_index_t;

  // channel payloads
  typedef struct packed {
    logic [3:0]  channel;
    logic [11:0] adc_code;
    logic        last_in_set;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         out_channel;
    logic signed [15:0] average_temperature_centi;
    logic               out_last_in_set;
  } out_item_t;

  // log2 unit handshake
  typedef struct packed {
    logic        start;
    logic [31:0] arg;
  } log_req_t;

  typedef struct packed {
    logic        done;
    logic [28:0] value;
  } log_rsp_t;

  typedef enum logic [1:0] {
    L_IDLE,
    L_NORM,
    L_SQR,
    L_DONE
  } log_state_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LGO,
    S_LWAIT,
    S_LN,
    S_DEN,
    S_NUM,
    S_CHK,
    S_DSAT,
    S_DIV,
    S_DEND,
    S_STORE,
    S_SUM,
    S_AVG,
    S_OUT
  } ctrl_state_t;

endpackage

`default_nettype wire

// ===== rtl/ntc_temperature_moving_average_core.sv =====
`default_nettype none

// NTC thermistor temperature with a per-channel moving average. Each item is one
// channel's 12-bit divider code; the result is the truncated mean, in 0.01 C, of
// that channel's last min(sets seen, FILTER_LEN) temperatures. One item is worked
// at a time: three log2 evaluations on a shared squaring unit (each a normalize
// step and 24 squarings), a 16-step restoring divider used at most once for the
// beta equation and once for the mean, and reads of up to FILTER_LEN entries from
// the history memory's single read port. The time an in-range item takes from its
// acceptance to its result is set by the leading zeros of the three log arguments;
// a full-scale code needs only two logs. Codes that saturate at once (code 0, zero
// registers) skip the logs and the beta divide. Items for channels at or beyond
// CHANNELS return their own temperature. A new item is taken while the previous
// result waits.
module ntc_temperature_moving_average_core
  import ntcma_pkg::*;
#(
  parameter int CHANNELS   = 4,
  parameter int FILTER_LEN = 8
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire in_item_t   in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output out_item_t       out_data,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [19:0] cfg_data
);

  localparam int DEPTH = CHANNELS * FILTER_LEN;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW    = (FILTER_LEN > 1) ? $clog2(FILTER_LEN) : 1;
  localparam int CW    = $clog2(FILTER_LEN + 1);
  localparam int SUMW  = 18 + $clog2(FILTER_LEN + 1);

  // configuration
  logic [19:0]        rf_r;
  logic [13:0]        beta_r;
  logic [19:0]        r0_r;
  logic signed [14:0] tref_r;

  // item and control
  ctrl_state_t state_r, state_nxt;
  logic [3:0]  ch_r;
  logic [11:0] adc_r;
  logic        last_r;
  logic [1:0]  lsel_r;
  logic        avg_mode_r;

  // datapath
  logic signed [31:0] acc_r;
  logic [30:0]        lnmag_r;
  logic               lnneg_r;
  logic signed [48:0] tlq_r;
  logic [20:0]        b100_r;
  logic signed [49:0] d_r;
  logic [36:0]        nb_r;
  logic [65:0]        rem_r;
  logic [65:0]        dvs_r;
  logic [15:0]        q_r;
  logic [3:0]         step_r;
  logic               sat_r;
  logic signed [16:0] temp_r;
  logic signed [SUMW-1:0] sum_r;
  logic               sneg_r;
  logic [CW-1:0]      idx_r;
  logic               rv_r;
  logic signed [15:0] avg_r;

  // ring state
  logic [SW-1:0] slot_r;
  logic [CW-1:0] fill_r;
  logic [CW-1:0] cnt;

  // history memory
  logic signed [16:0] hist_mem [DEPTH];
  logic signed [16:0] rd_data_r;
  logic [AW-1:0]      wr_addr;
  logic [AW-1:0]      rd_addr;
  logic               mem_we;
  logic               rd_issue;
  logic [31:0]        base_addr;

  logic      out_valid_r;
  out_item_t out_data_r;

  log_req_t log_req;
  log_rsp_t log_rsp;

  logic               ch_ok;
  logic               special;
  logic               full;
  logic [30:0]        acc_mag;
  logic [60:0]        ln_prod;
  logic signed [31:0] lq;
  logic signed [16:0] t0c;
  logic [15:0]        q_clip;
  logic [SUMW-1:0]    sum_mag;

  assign ch_ok   = (5'(ch_r) < 5'(CHANNELS));
  assign full    = (adc_r == CODE_FULL);
  assign special = (beta_r == '0) || (r0_r == '0) || (rf_r == '0) || (in_data.adc_code == '0);
  assign cnt     = (fill_r < CW'(FILTER_LEN)) ? fill_r + CW'(1) : CW'(FILTER_LEN);
  assign t0c     = 17'({{2{tref_r[14]}}, tref_r}) + $signed(KELVIN_CENTI);
  assign acc_mag = acc_r[31] ? 31'(-acc_r) : acc_r[30:0];
  assign ln_prod = {30'b0, acc_mag} * {31'b0, LN2_Q30};
  assign lq      = lnneg_r ? -$signed({1'b0, lnmag_r}) : $signed({1'b0, lnmag_r});
  assign q_clip  = (sat_r || q_r > QUOT_MAX) ? QUOT_MAX : q_r;
  assign sum_mag = sum_r[SUMW-1] ? SUMW'(-sum_r) : SUMW'(sum_r);

  assign base_addr = 32'(ch_r) * 32'(FILTER_LEN);
  assign wr_addr   = AW'(base_addr + 32'(slot_r));
  assign rd_addr   = AW'(base_addr + 32'(idx_r));

  // shared log2 unit
  always_comb begin
    log_req.start = (state_r == S_LGO);
    unique case (lsel_r)
      2'd0:    log_req.arg = full ? 32'(rf_r) * 32'd100 : 32'(adc_r) * 32'(rf_r);
      2'd1:    log_req.arg = 32'(CODE_FULL - adc_r);
      default: log_req.arg = 32'(r0_r);
    endcase
  end

  ntcma_log2 u_log2 (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (log_req),
    .rsp   (log_rsp)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = special ? S_STORE : S_LGO;
      S_LGO:   state_nxt = S_LWAIT;
      S_LWAIT: if (log_rsp.done) state_nxt = (lsel_r == 2'd2) ? S_LN : S_LGO;
      S_LN:    state_nxt = S_DEN;
      S_DEN:   state_nxt = S_NUM;
      S_NUM:   state_nxt = S_CHK;
      S_CHK:   state_nxt = (d_r <= 0) ? S_STORE : S_DSAT;
      S_DSAT:  state_nxt = (rem_r >= {dvs_r[64:0], 1'b0}) ? S_DEND : S_DIV;
      S_DIV:   if (step_r == 4'(DIV_STEPS - 1)) state_nxt = S_DEND;
      S_DEND:  state_nxt = avg_mode_r ? S_OUT : S_STORE;
      S_STORE: state_nxt = ch_ok ? S_SUM : S_OUT;
      S_SUM:   if (!rd_issue && !rv_r) state_nxt = S_AVG;
      S_AVG:   state_nxt = S_DSAT;
      S_OUT:   if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready = (state_r == S_IDLE);
    mem_we   = (state_r == S_STORE) && ch_ok;
    rd_issue = (state_r == S_SUM) && (idx_r < cnt);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      slot_r      <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      rv_r        <= 1'b0;
      rf_r        <= 20'd10000;
      beta_r      <= 14'd3950;
      r0_r        <= 20'd10000;
      tref_r      <= 15'sd2500;
    end else begin
      state_r <= state_nxt;
      rv_r    <= rd_issue;
      // configuration writes
      if (cfg_we) begin
        unique case (cfg_index_t'(cfg_index))
          CFG_FIXED_RES: rf_r   <= cfg_data;
          CFG_BETA:      beta_r <= cfg_data[13:0];
          CFG_REF_RES:   r0_r   <= cfg_data;
          CFG_REF_TEMP:  tref_r <= $signed(cfg_data[14:0]);
          default:       ;
        endcase
      end
      // result register and ring advance
      if (state_r == S_OUT && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
        if (last_r) begin
          slot_r <= (slot_r == SW'(FILTER_LEN - 1)) ? '0 : slot_r + SW'(1);
          fill_r <= cnt;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        ch_r       <= in_data.channel;
        adc_r      <= in_data.adc_code;
        last_r     <= in_data.last_in_set;
        lsel_r     <= 2'd0;
        avg_mode_r <= 1'b0;
        temp_r     <= TEMP_LOW;
      end
      S_LGO: begin
      end
      S_LWAIT: begin
        if (log_rsp.done) begin
          if (lsel_r == 2'd0) begin
            acc_r  <= $signed({3'b0, log_rsp.value});
            lsel_r <= full ? 2'd2 : 2'd1;
          end else begin
            acc_r  <= acc_r - $signed({3'b0, log_rsp.value});
            lsel_r <= 2'd2;
          end
        end
      end
      S_LN: begin
        lnmag_r <= ln_prod[60:30];
        lnneg_r <= acc_r[31];
      end
      S_DEN: begin
        tlq_r  <= 49'(t0c) * 49'(lq);
        b100_r <= 21'(beta_r) * 21'd100;
      end
      S_NUM: begin
        d_r  <= $signed({5'b0, b100_r, 24'b0}) + 50'(tlq_r);
        nb_r <= 37'(b100_r) * 37'(t0c[15:0]);
      end
      S_CHK: begin
        temp_r <= (d_r == 0) ? TEMP_HIGH : TEMP_LOW;
        rem_r  <= 66'({nb_r, 24'b0}) + 66'(d_r[48:1]);
        dvs_r  <= 66'(d_r[48:0]) << 15;
      end
      S_DSAT: begin
        sat_r  <= (rem_r >= {dvs_r[64:0], 1'b0});
        q_r    <= '0;
        step_r <= '0;
      end
      S_DIV: begin
        step_r <= step_r + 4'd1;
        dvs_r  <= dvs_r >> 1;
        if (rem_r >= dvs_r) begin
          rem_r <= rem_r - dvs_r;
          q_r   <= {q_r[14:0], 1'b1};
        end else begin
          q_r   <= {q_r[14:0], 1'b0};
        end
      end
      S_DEND: begin
        temp_r <= $signed({1'b0, q_clip}) - $signed(KELVIN_CENTI);
        avg_r  <= sneg_r ? -$signed(sat_r ? 16'hFFFF : q_r)
                         : $signed(sat_r ? 16'hFFFF : q_r);
      end
      S_STORE: begin
        avg_r <= temp_r[15:0];
        sum_r <= '0;
        idx_r <= '0;
      end
      S_SUM: begin
        if (rd_issue) idx_r <= idx_r + CW'(1);
        if (rv_r) sum_r <= sum_r + SUMW'(rd_data_r);
      end
      S_AVG: begin
        avg_mode_r <= 1'b1;
        sneg_r     <= sum_r[SUMW-1];
        rem_r      <= 66'(sum_mag);
        dvs_r      <= 66'(cnt) << 15;
      end
      S_OUT: begin
      end
      default: begin
      end
    endcase
    if (state_r == S_OUT && (!out_valid_r || out_ready)) begin
      out_data_r.out_channel               <= ch_r;
      out_data_r.average_temperature_centi <= avg_r;
      out_data_r.out_last_in_set           <= last_r;
    end
  end

  // history memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) hist_mem[wr_addr] <= temp_r;
  end

  always_ff @(posedge clk) begin
    rd_data_r <= hist_mem[rd_addr];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(FILTER_LEN)) else $error("fill count beyond filter length");

  a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= SW'(FILTER_LEN - 1)) else $error("write slot beyond ring");

  a_we_channel: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (5'(ch_r) < 5'(CHANNELS))) else $error("history write for bad channel");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("second item taken while busy");

  a_ln_after_logs: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LN) |-> (lsel_r == 2'd2)) else $error("ln started before all logs");

endmodule

`default_nettype wire

// ===== rtl/ntcma_log2.sv =====
`default_nettype none

module ntcma_log2
  import ntcma_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire log_req_t req,
  output log_rsp_t      rsp
);

  log_state_t state_r, state_nxt;

  logic [31:0] x_r;
  logic [4:0]  e_r;
  logic [30:0] m_r;
  logic [FRAC_BITS-1:0] frac_r;
  logic [4:0]  step_r;

  logic [61:0] sq;
  logic [31:0] sq_hi;

  // one squaring of the q30 mantissa per cycle
  assign sq    = {31'b0, m_r} * {31'b0, m_r};
  assign sq_hi = sq[61:30];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      L_IDLE: if (req.start) state_nxt = L_NORM;
      L_NORM: if (x_r[31]) state_nxt = L_SQR;
      L_SQR:  if (step_r == 5'(FRAC_BITS - 1)) state_nxt = L_DONE;
      L_DONE: state_nxt = L_IDLE;
      default: state_nxt = L_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    rsp.done  = (state_r == L_DONE);
    rsp.value = {e_r, frac_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // normalize by nibbles then bits, then square
  always_ff @(posedge clk) begin
    unique case (state_r)
      L_IDLE: begin
        x_r    <= req.arg;
        e_r    <= 5'd31;
        step_r <= '0;
        frac_r <= '0;
      end
      L_NORM: begin
        if (x_r[31:28] == 4'b0) begin
          x_r <= {x_r[27:0], 4'b0};
          e_r <= e_r - 5'd4;
        end else if (!x_r[31]) begin
          x_r <= {x_r[30:0], 1'b0};
          e_r <= e_r - 5'd1;
        end else begin
          m_r <= x_r[31:1];
        end
      end
      L_SQR: begin
        step_r <= step_r + 5'd1;
        if (sq_hi[31]) begin
          m_r    <= sq_hi[31:1];
          frac_r <= {frac_r[FRAC_BITS-2:0], 1'b1};
        end else begin
          m_r    <= sq_hi[30:0];
          frac_r <= {frac_r[FRAC_BITS-2:0], 1'b0};
        end
      end
      L_DONE: begin
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`default_nettype none

module tb_top;
  import ntcma_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CHANNELS   = 4;
  localparam int FILTER_LEN = 8;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_FIXED_RES;
  logic [19:0] cfg_data = '0;

  ntc_temperature_moving_average_core #(
    .CHANNELS(CHANNELS),
    .FILTER_LEN(FILTER_LEN)
  ) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow copy of the registers and the filter state
  longint rf_ohms = 10000;
  longint beta = 3950;
  longint r0_ohms = 10000;
  longint t0_centi = 2500;
  int hist [CHANNELS][FILTER_LEN];
  int slot_ptr = 0;
  int fill_cnt = 0;

  in_item_t  sample_q[$];
  out_item_t avg_q[$];
  int errors = 0;
  bit calm = 1'b0;
  int stall_cnt = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // log2 with 24 fraction bits by repeated squaring
  function automatic longint unsigned log2_fx(longint unsigned x);
    int e;
    longint unsigned m;
    longint unsigned fr;
    e = 0;
    fr = 0;
    while (e < 63 && (x >> (e + 1)) != 0) e++;
    if (e <= 30) m = x << (30 - e);
    else m = x >> (e - 30);
    for (int i = 0; i < 24; i++) begin
      m = (m * m) >> 30;
      fr = fr << 1;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        fr = fr | 1;
      end
    end
    return (longint'(e) << 24) | fr;
  endfunction

  // beta equation, saturated temperature in 0.01 C
  function automatic int code_temp(int adc);
    longint l2, lq, t0c, d, n, t;
    longint unsigned mag;
    if (beta == 0 || r0_ohms == 0 || rf_ohms == 0 || adc == 0) return -27315;
    if (adc >= 4095)
      l2 = longint'(log2_fx(100 * rf_ohms)) - longint'(log2_fx(r0_ohms));
    else
      l2 = longint'(log2_fx(adc * rf_ohms)) - longint'(log2_fx(4095 - adc))
         - longint'(log2_fx(r0_ohms));
    mag = (l2 < 0) ? -l2 : l2;
    lq = longint'((mag * 744261118) >> 30);
    if (l2 < 0) lq = -lq;
    t0c = t0_centi + 27315;
    d = beta * 64'sd1677721600 + t0c * lq;
    if (d == 0) return 30000;
    if (d < 0) return -27315;
    n = beta * t0c * 64'sd1677721600;
    t = (n + d / 2) / d - 27315;
    if (t > 30000) t = 30000;
    if (t < -27315) t = -27315;
    return int'(t);
  endfunction

  // update filter state for one accepted item and queue its average
  task automatic predict_average(in_item_t it);
    int temp, avg, cnt, sum;
    out_item_t r;
    temp = code_temp(int'(it.adc_code));
    avg = temp;
    cnt = (fill_cnt < FILTER_LEN) ? fill_cnt + 1 : FILTER_LEN;
    if (it.channel < CHANNELS) begin
      sum = 0;
      hist[it.channel][slot_ptr] = temp;
      for (int i = 0; i < cnt; i++) sum += hist[it.channel][i];
      avg = sum / cnt;
    end
    if (it.last_in_set) begin
      slot_ptr = (slot_ptr + 1) % FILTER_LEN;
      fill_cnt = cnt;
    end
    r.out_channel = it.channel;
    r.average_temperature_centi = avg[15:0];
    r.out_last_in_set = it.last_in_set;
    avg_q.push_back(r);
  endtask

  // driver
  always @(posedge clk) begin
    logic take;
    take = in_valid && in_ready;
    if (rst_n) begin
      if (take) predict_average(in_data);
      if (!in_valid || take) begin
        if (sample_q.size() > 0 && (calm || $urandom_range(0, 99) >= 10)) begin
          in_valid <= 1'b1;
          in_data <= sample_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      out_ready <= calm || ($urandom_range(0, 99) >= 10);
      if (out_valid && out_ready) begin
        if (avg_q.size() == 0) begin
          $error("unexpected result item: channel %0d", out_data.out_channel);
          errors++;
        end else begin
          want = avg_q.pop_front();
          if (out_data.out_channel !== want.out_channel) begin
            $error("out_channel: expected %0d, got %0d", want.out_channel,
                   out_data.out_channel);
            errors++;
          end
          if (out_data.average_temperature_centi !== want.average_temperature_centi) begin
            $error("average_temperature_centi: expected %0d, got %0d",
                   want.average_temperature_centi, out_data.average_temperature_centi);
            errors++;
          end
          if (out_data.out_last_in_set !== want.out_last_in_set) begin
            $error("out_last_in_set: expected %0d, got %0d", want.out_last_in_set,
                   out_data.out_last_in_set);
            errors++;
          end
        end
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cnt <= 0;
      else stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic write_reg(cfg_index_t idx, int val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[19:0];
    case (idx)
      CFG_FIXED_RES: rf_ohms = val & 20'hFFFFF;
      CFG_BETA:      beta = val & 14'h3FFF;
      CFG_REF_RES:   r0_ohms = val & 20'hFFFFF;
      CFG_REF_TEMP:  t0_centi = longint'($signed(val[14:0]));
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(int rf, int b, int r0, int t0);
    write_reg(CFG_FIXED_RES, rf);
    write_reg(CFG_BETA, b);
    write_reg(CFG_REF_RES, r0);
    write_reg(CFG_REF_TEMP, t0);
  endtask

  // sender holds off until every result is back, then the core settles
  task automatic drain();
    while (sample_q.size() > 0 || in_valid || avg_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [11:0] pick_code();
    case ($urandom_range(0, 9))
      0: return 12'd0;
      1: return 12'd4095;
      2: return 12'($urandom_range(1, 3));
      3: return 12'($urandom_range(4092, 4094));
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic in_item_t mk(int ch, logic [11:0] code, bit last);
    in_item_t it;
    it.channel = ch[3:0];
    it.adc_code = code;
    it.last_in_set = last;
    return it;
  endfunction

  // one sampling set: every live channel once, shuffled, plus optional extras
  task automatic queue_set(output int n);
    int order[$];
    in_item_t items[$];
    int extra;
    for (int c = 0; c < CHANNELS; c++) order.push_back(c);
    order.shuffle();
    foreach (order[i]) items.push_back(mk(order[i], pick_code(), 1'b0));
    extra = ($urandom_range(0, 99) < 30) ? $urandom_range(1, 3) : 0;
    for (int k = 0; k < extra; k++) begin
      if ($urandom_range(0, 1))
        items.insert($urandom_range(0, items.size()),
                     mk($urandom_range(CHANNELS, 15), pick_code(), 1'b0));
      else
        items.insert($urandom_range(0, items.size()),
                     mk($urandom_range(0, CHANNELS - 1), pick_code(), 1'b0));
    end
    items[items.size() - 1].last_in_set = 1'b1;
    foreach (items[i]) sample_q.push_back(items[i]);
    n = items.size();
  endtask

  initial begin
    int sent;
    int n;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: code extremes, out-of-range channels, set ends on either kind
    sample_q.push_back(mk(0, 12'd0, 1'b0));
    sample_q.push_back(mk(1, 12'd1, 1'b0));
    sample_q.push_back(mk(2, 12'd4095, 1'b0));
    sample_q.push_back(mk(15, 12'd4094, 1'b0));
    sample_q.push_back(mk(3, 12'd2047, 1'b1));
    sample_q.push_back(mk(3, 12'd4095, 1'b0));
    sample_q.push_back(mk(4, 12'd100, 1'b0));
    sample_q.push_back(mk(0, 12'd4094, 1'b0));
    sample_q.push_back(mk(1, 12'd0, 1'b0));
    sample_q.push_back(mk(2, 12'd1, 1'b0));
    sample_q.push_back(mk(9, 12'd3000, 1'b1));
    sample_q.push_back(mk(2, 12'hAAA, 1'b0));
    sample_q.push_back(mk(1, 12'h555, 1'b0));
    sample_q.push_back(mk(0, 12'hFFF, 1'b0));
    sample_q.push_back(mk(3, 12'h800, 1'b0));
    sample_q.push_back(mk(10, 12'h7FF, 1'b1));
    drain();

    // random phases, each with its own register setting
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_regs(1, 1000, 1, -4000);
        1: set_regs(1000000, 10000, 1000000, 15000);
        2: set_regs(1048575, 16383, 1, -16384);
        3: set_regs(0, 3950, 10000, 16383);
        4: set_regs(10000, 0, 0, 2500);
        5: set_regs(10000, 3950, 10000, 2500);
        default: set_regs($urandom_range(1, 1048575), $urandom_range(1000, 16383),
                          $urandom_range(1, 1048575), $urandom_range(0, 32767));
      endcase
      calm = (ph == 5);
      sent = 0;
      while (sent < 230) begin
        queue_set(n);
        sent += n;
      end
      drain();
      calm = 1'b0;
    end

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
